@@ hw/rtl/plid_pkg.sv @@
// Package for the positional list insert/delete unit.
// Widths, command and status codes, sequencer states and shared structs.
// Depends on nothing.
`default_nettype none

package plid_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 11;
   localparam int ITEM_W   = 11;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MOVE,
      SEQ_PUT,
      SEQ_RDWAIT,
      SEQ_DONE
   } seq_state_type;

   // one write port and one read port per cycle
   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic signed [DATA_W-1:0] wdata;
      logic                     re;
      logic [ADDR_W-1:0]        raddr;
   } mem_ctl_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         count;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/positional_list_insert_delete_unit.sv @@
// Positional list insert/delete unit: top level.
// Depends on plid_pkg, plid_seq and plid_store.
//
// Keeps a packed list of up to CAPACITY signed 32-bit values in one memory.
// Request word (req_*): cmd 0 insert after req_position elements, 1 delete
// the req_position-th element (1-based), 2 read 0-based index. Every
// request gives one response word (rsp_*) with status, read value (zero
// unless a good read) and the element count after the command.
// One request is in work at a time; req_stall is high while it runs.
// Steps from accept to response valid (output register free):
//   insert   : shift count - position elements up, then write the new value
//   delete   : shift count - position elements down
//   read     : one registered store read
//   rejected : straight to the response
// Insert and delete move one element per cycle through the store's single
// read and write port.
// The response sits in an output register; a new request is taken while it
// waits on rsp_stall, and the next result waits until it is drained.
// Synchronous reset empties the list; store contents are not cleared.
`default_nettype none

module positional_list_insert_delete_unit import plid_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_data_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STAT_W-1:0]             rsp_status,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic [ITEM_W-1:0]             rsp_item_count
);

   mem_ctl_type              mem_ctl;
   logic signed [DATA_W-1:0] rd_data;
   logic                     seq_idle;
   logic                     seq_done;
   result_type               seq_result;
   logic                     req_accept;
   logic                     out_free;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ITEM_W-1:0]        rsp_count_ff, rsp_count_in;

   assign req_stall  = !seq_idle;
   assign req_accept = req_valid && !req_stall;
   // output register can take a word this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   plid_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .cmd        (req_cmd),
      .position   (req_position),
      .data_value (req_data_value),
      .out_free   (out_free),
      .rd_data    (rd_data),
      .mem_ctl    (mem_ctl),
      .idle       (seq_idle),
      .done       (seq_done),
      .result     (seq_result)
   );

   plid_store u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (seq_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = seq_result.status;
         rsp_value_in  = seq_result.value;
         rsp_count_in  = ITEM_W'(seq_result.count);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_item_count = rsp_count_ff;

   // every accepted word takes the sequencer out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("sequencer still idle after accept");

   // a finished word never overwrites a waiting response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten");

   // list-full status only with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_item_count == ITEM_W'(CAPACITY)))
      else $error("full status with list not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      seq_result.count <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

endmodule

`default_nettype wire

@@ hw/rtl/plid_store.sv @@
// Element store: CAPACITY x 32 array, one write and one registered read per cycle.
// Depends on plid_pkg.
`default_nettype none

module plid_store import plid_pkg::*; (
   input  wire logic               clock,
   input  wire mem_ctl_type        mem_ctl,
   output logic signed [DATA_W-1:0] rd_data_ff
);

   logic signed [DATA_W-1:0] store_mem_ff [CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         store_mem_ff[mem_ctl.waddr] <= mem_ctl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.re) begin
         rd_data_ff <= store_mem_ff[mem_ctl.raddr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/plid_seq.sv @@
// Command sequencer: decodes a word, walks the shift engine over the store,
// keeps the element count and builds the result. Depends on plid_pkg.
`default_nettype none

module plid_seq import plid_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [CMD_W-1:0]         cmd,
   input  wire logic [POS_W-1:0]         position,
   input  wire logic signed [DATA_W-1:0] data_value,
   input  wire logic                     out_free,
   input  wire logic signed [DATA_W-1:0] rd_data,
   output mem_ctl_type                   mem_ctl,
   output logic                          idle,
   output logic                          done,
   output result_type                    result
);

   seq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        src_ff, src_in;
   logic [ADDR_W-1:0]        wdst_ff, wdst_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     pend_ff, pend_in;
   logic                     up_ff, up_in;
   logic                     ins_ff, ins_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      wdst_ff   <= wdst_in;
      left_ff   <= left_in;
      up_ff     <= up_in;
      ins_ff    <= ins_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      wdst_in   = wdst_ff;
      left_in   = left_ff;
      pend_in   = pend_ff;
      up_in     = up_ff;
      ins_in    = ins_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      value_in  = value_ff;
      mem_ctl   = '0;
      done      = 1'b0;
      idle      = (state_ff == SEQ_IDLE);

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               value_in  = '0;
               status_in = STAT_RANGE;
               pend_in   = 1'b0;
               state_in  = SEQ_DONE;
               unique case (cmd)
                  CMD_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        status_in = STAT_DONE;
                        ins_in    = 1'b1;
                        up_in     = 1'b0;
                        src_in    = ADDR_W'(cnt_ext - CMP_W'(1));
                        left_in   = CNT_W'(cnt_ext - pos_ext);
                        pos_in    = ADDR_W'(pos_ext);
                        val_in    = data_value;
                        count_in  = CNT_W'(cnt_ext + CMP_W'(1));
                        state_in  = SEQ_MOVE;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else begin
                        // left may be zero when the last element goes
                        status_in = STAT_DONE;
                        ins_in    = 1'b0;
                        up_in     = 1'b1;
                        src_in    = ADDR_W'(pos_ext);
                        left_in   = CNT_W'(cnt_ext - pos_ext);
                        count_in  = CNT_W'(cnt_ext - CMP_W'(1));
                        state_in  = SEQ_MOVE;
                     end
                  end
                  CMD_READ: begin
                     if (pos_ext < cnt_ext) begin
                        status_in     = STAT_DONE;
                        mem_ctl.re    = 1'b1;
                        mem_ctl.raddr = ADDR_W'(pos_ext);
                        state_in      = SEQ_RDWAIT;
                     end
                  end
                  default: begin
                     status_in = STAT_RANGE;
                  end
               endcase
            end
         end

         SEQ_MOVE: begin
            // write back the word read last cycle
            if (pend_ff) begin
               mem_ctl.we    = 1'b1;
               mem_ctl.waddr = wdst_ff;
               mem_ctl.wdata = rd_data;
            end
            if (left_ff != '0) begin
               mem_ctl.re    = 1'b1;
               mem_ctl.raddr = src_ff;
               pend_in       = 1'b1;
               wdst_in       = up_ff ? src_ff - 1'b1 : src_ff + 1'b1;
               src_in        = up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
               left_in       = left_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ins_ff ? SEQ_PUT : SEQ_DONE;
            end
         end

         SEQ_PUT: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = pos_ff;
            mem_ctl.wdata = val_ff;
            state_in      = SEQ_DONE;
         end

         SEQ_RDWAIT: begin
            value_in = rd_data;
            state_in = SEQ_DONE;
         end

         SEQ_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign result.status = status_ff;
   assign result.value  = value_ff;
   assign result.count  = count_ff;

endmodule

`default_nettype wire
